[hw/rtl/fae_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none

package fae_pkg;

  // Default sizing
  localparam int unsigned DATA_WIDTH  = 32;
  localparam int unsigned QUEUE_DEPTH = 2;
  localparam int unsigned IMM_W       = 32;
  localparam int unsigned OUT_W       = 32;

  // Operation codes on the instruction channel
  localparam logic [3:0] OPC_EMPTY = 4'd0;
  localparam logic [3:0] OPC_MOV   = 4'd1;
  localparam logic [3:0] OPC_ADD   = 4'd2;
  localparam logic [3:0] OPC_SUB   = 4'd3;
  localparam logic [3:0] OPC_MUL   = 4'd4;
  localparam logic [3:0] OPC_DIV   = 4'd5;
  localparam logic [3:0] OPC_INC   = 4'd6;
  localparam logic [3:0] OPC_DEC   = 4'd7;
  localparam logic [3:0] OPC_END   = 4'd8;

  // Destination register names
  localparam logic [2:0] DEST_AX = 3'd1;
  localparam logic [2:0] DEST_DX = 3'd4;

  typedef enum logic [2:0] {
    ST_OK     = 3'd0,
    ST_EMPTY  = 3'd1,
    ST_BADREG = 3'd2,
    ST_END    = 3'd3,
    ST_DIVZ   = 3'd4,
    ST_BADINS = 3'd5,
    ST_HALTED = 3'd6
  } status_e;

  // Arithmetic operations; the code doubles as the mnemonic record
  typedef enum logic [2:0] {
    OP_NONE = 3'd0,
    OP_MOV  = 3'd1,
    OP_ADD  = 3'd2,
    OP_SUB  = 3'd3,
    OP_MUL  = 3'd4,
    OP_DIV  = 3'd5,
    OP_INC  = 3'd6,
    OP_DEC  = 3'd7
  } alu_op_e;

  typedef enum logic [1:0] {
    REG_A = 2'd0,
    REG_B = 2'd1,
    REG_C = 2'd2,
    REG_D = 2'd3
  } reg_sel_e;

  // Classified instruction handed from front to back
  typedef struct packed {
    logic             arith;
    status_e          fixed_status;
    alu_op_e          op;
    logic             dest_ok;
    reg_sel_e         dest_sel;
    logic             src_is_reg;
    reg_sel_e         src_sel;
    logic [IMM_W-1:0] imm;
  } entry_t;

  typedef struct packed {
    logic start;
    logic is_div;
  } mdu_req_t;

  typedef struct packed {
    logic busy;
    logic done;
  } mdu_rsp_t;

endpackage

`default_nettype wire

[hw/rtl/fae_if.sv]
`timescale 1ns / 1ps
`default_nettype none

// Instruction channel
interface fae_instr_if;
  logic               valid;
  logic               ready;
  logic [3:0]         operation;
  logic               malformed;
  logic [2:0]         dest_reg;
  logic               source_is_register;
  logic [1:0]         source_reg;
  logic signed [31:0] immediate;

  modport source (
    output valid, operation, malformed, dest_reg, source_is_register, source_reg,
           immediate,
    input  ready
  );
  modport sink (
    input  valid, operation, malformed, dest_reg, source_is_register, source_reg,
           immediate,
    output ready
  );
endinterface

// Result channel
interface fae_result_if;
  logic               valid;
  logic               ready;
  logic [2:0]         status;
  logic [31:0]        pc_out;
  logic signed [31:0] a_out;
  logic signed [31:0] b_out;
  logic signed [31:0] c_out;
  logic signed [31:0] d_out;
  logic [2:0]         mnemonic_out;

  modport source (
    output valid, status, pc_out, a_out, b_out, c_out, d_out, mnemonic_out,
    input  ready
  );
  modport sink (
    input  valid, status, pc_out, a_out, b_out, c_out, d_out, mnemonic_out,
    output ready
  );
endinterface

`default_nettype wire

[hw/rtl/fae_front.sv]
`timescale 1ns / 1ps
`default_nettype none

module fae_front (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  fae_instr_if.sink            instr_i,
  output logic                 push_valid_o,
  input  wire logic            push_ready_i,
  output fae_pkg::entry_t      push_entry_o
);

  logic            fv_q;
  fae_pkg::entry_t fe_q;
  fae_pkg::entry_t cls;
  logic [2:0]      dest_m1;
  logic            accept;

  // Decode the word into a queue entry
  always_comb begin
    dest_m1          = instr_i.dest_reg - 3'd1;
    cls.arith        = 1'b0;
    cls.fixed_status = fae_pkg::ST_OK;
    cls.op           = fae_pkg::OP_NONE;
    cls.dest_ok      = (instr_i.dest_reg >= fae_pkg::DEST_AX) &&
                       (instr_i.dest_reg <= fae_pkg::DEST_DX);
    cls.dest_sel     = fae_pkg::reg_sel_e'(dest_m1[1:0]);
    cls.src_is_reg   = instr_i.source_is_register;
    cls.src_sel      = fae_pkg::reg_sel_e'(instr_i.source_reg);
    cls.imm          = instr_i.immediate;
    if (instr_i.malformed) begin
      cls.fixed_status = fae_pkg::ST_BADREG;
    end else begin
      case (instr_i.operation)
        fae_pkg::OPC_EMPTY: begin
          cls.fixed_status = fae_pkg::ST_EMPTY;
        end
        fae_pkg::OPC_END: begin
          cls.fixed_status = fae_pkg::ST_END;
        end
        fae_pkg::OPC_MOV, fae_pkg::OPC_ADD, fae_pkg::OPC_SUB, fae_pkg::OPC_MUL,
        fae_pkg::OPC_DIV, fae_pkg::OPC_INC, fae_pkg::OPC_DEC: begin
          cls.arith = 1'b1;
          cls.op    = fae_pkg::alu_op_e'(instr_i.operation[2:0]);
        end
        default: begin
          cls.fixed_status = fae_pkg::ST_BADINS;
        end
      endcase
    end
  end

  assign instr_i.ready = !fv_q || push_ready_i;
  assign accept        = instr_i.valid && instr_i.ready;
  assign push_valid_o  = fv_q;
  assign push_entry_o  = fe_q;

  // Holding register in front of the queue
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fv_q <= 1'b0;
    end else if (accept) begin
      fv_q <= 1'b1;
    end else if (push_ready_i) begin
      fv_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      fe_q <= cls;
    end
  end

endmodule

`default_nettype wire

[hw/rtl/fae_queue.sv]
`timescale 1ns / 1ps
`default_nettype none

module fae_queue #(
  parameter int unsigned DEPTH = fae_pkg::QUEUE_DEPTH
) (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            push_valid_i,
  output logic                 push_ready_o,
  input  wire fae_pkg::entry_t push_entry_i,
  output logic                 pop_valid_o,
  input  wire logic            pop_ready_i,
  output fae_pkg::entry_t      pop_entry_o
);

  localparam int unsigned PTR_W = $clog2(DEPTH);
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  fae_pkg::entry_t  slot_q [DEPTH];
  logic [PTR_W-1:0] wr_ptr_q;
  logic [PTR_W-1:0] rd_ptr_q;
  logic [CNT_W-1:0] cnt_q;
  logic             push;
  logic             pop;

  assign push_ready_o = cnt_q != CNT_W'(DEPTH);
  assign pop_valid_o  = cnt_q != '0;
  assign push         = push_valid_i && push_ready_o;
  assign pop          = pop_valid_o && pop_ready_i;
  assign pop_entry_o  = slot_q[rd_ptr_q];

  // Pointers and fill count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (push) begin
        wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + PTR_W'(1);
      end
      if (pop) begin
        rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + PTR_W'(1);
      end
      if (push && !pop) begin
        cnt_q <= cnt_q + CNT_W'(1);
      end else if (pop && !push) begin
        cnt_q <= cnt_q - CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      slot_q[wr_ptr_q] <= push_entry_i;
    end
  end

endmodule

`default_nettype wire

[hw/rtl/fae_mdu.sv]
`timescale 1ns / 1ps
`default_nettype none

// Shared shift-add multiplier and restoring divider, one bit per cycle
module fae_mdu #(
  parameter int unsigned DATA_WIDTH = fae_pkg::DATA_WIDTH
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire fae_pkg::mdu_req_t     req_i,
  input  wire logic [DATA_WIDTH-1:0] a_i,
  input  wire logic [DATA_WIDTH-1:0] b_i,
  output fae_pkg::mdu_rsp_t          rsp_o,
  output logic [DATA_WIDTH-1:0]      res_o
);

  localparam int unsigned DW    = DATA_WIDTH;
  localparam int unsigned CNT_W = $clog2(DW);

  typedef enum logic [3:0] {
    M_IDLE = 4'b0001,
    M_STEP = 4'b0010,
    M_FIX  = 4'b0100,
    M_DONE = 4'b1000
  } mdu_state_e;

  mdu_state_e       state_q, state_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic             is_div_q, is_div_d;
  logic             neg_q, neg_d;
  logic [DW:0]      acc_q, acc_d;
  logic [DW-1:0]    sh_q, sh_d;
  logic [DW-1:0]    opd_q, opd_d;
  logic [DW-1:0]    res_q, res_d;

  logic [DW-1:0]    mag_a;
  logic [DW-1:0]    mag_b;
  logic [DW:0]      rem_sh;
  logic [DW:0]      diff;
  logic [DW-1:0]    fin;

  always_comb begin
    mag_a  = a_i[DW-1] ? -a_i : a_i;
    mag_b  = b_i[DW-1] ? -b_i : b_i;
    rem_sh = {acc_q[DW-1:0], sh_q[DW-1]};
    diff   = rem_sh - {1'b0, opd_q};
    fin    = is_div_q ? sh_q : acc_q[DW-1:0];

    state_d  = state_q;
    cnt_d    = cnt_q;
    is_div_d = is_div_q;
    neg_d    = neg_q;
    acc_d    = acc_q;
    sh_d     = sh_q;
    opd_d    = opd_q;
    res_d    = res_q;

    case (state_q)
      M_IDLE: begin
        if (req_i.start) begin
          cnt_d    = '0;
          acc_d    = '0;
          is_div_d = req_i.is_div;
          if (req_i.is_div) begin
            sh_d  = mag_a;
            opd_d = mag_b;
            neg_d = a_i[DW-1] ^ b_i[DW-1];
          end else begin
            sh_d  = b_i;
            opd_d = a_i;
            neg_d = 1'b0;
          end
          state_d = M_STEP;
        end
      end
      M_STEP: begin
        if (is_div_q) begin
          // Restoring step: shift in next dividend bit, try subtract
          if (!diff[DW]) begin
            acc_d = diff;
            sh_d  = {sh_q[DW-2:0], 1'b1};
          end else begin
            acc_d = rem_sh;
            sh_d  = {sh_q[DW-2:0], 1'b0};
          end
        end else begin
          acc_d = {1'b0, acc_q[DW-1:0] + (sh_q[0] ? opd_q : '0)};
          opd_d = {opd_q[DW-2:0], 1'b0};
          sh_d  = {1'b0, sh_q[DW-1:1]};
        end
        cnt_d = cnt_q + CNT_W'(1);
        if (cnt_q == CNT_W'(DW - 1)) begin
          state_d = M_FIX;
        end
      end
      M_FIX: begin
        // Sign fix of the quotient; the product passes through unchanged
        res_d   = neg_q ? -fin : fin;
        state_d = M_DONE;
      end
      M_DONE: begin
        state_d = M_IDLE;
      end
      default: begin
        state_d = M_IDLE;
      end
    endcase
  end

  assign rsp_o.busy = state_q != M_IDLE;
  assign rsp_o.done = state_q == M_DONE;
  assign res_o      = res_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= M_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cnt_q    <= cnt_d;
    is_div_q <= is_div_d;
    neg_q    <= neg_d;
    acc_q    <= acc_d;
    sh_q     <= sh_d;
    opd_q    <= opd_d;
    res_q    <= res_d;
  end

endmodule

`default_nettype wire

[hw/rtl/fae_back.sv]
`timescale 1ns / 1ps
`default_nettype none

module fae_back #(
  parameter int unsigned DATA_WIDTH = fae_pkg::DATA_WIDTH
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  pop_valid_i,
  output logic                       pop_ready_o,
  input  wire fae_pkg::entry_t       pop_entry_i,
  output fae_pkg::mdu_req_t          mdu_req_o,
  input  wire fae_pkg::mdu_rsp_t     mdu_rsp_i,
  output logic [DATA_WIDTH-1:0]      mdu_a_o,
  output logic [DATA_WIDTH-1:0]      mdu_b_o,
  input  wire logic [DATA_WIDTH-1:0] mdu_res_i,
  fae_result_if.source               result_o
);

  localparam int unsigned DW = DATA_WIDTH;

  typedef enum logic [1:0] {
    B_IDLE = 2'b01,
    B_CALC = 2'b10
  } back_state_e;

  function automatic logic [fae_pkg::OUT_W-1:0] to_out(logic [DW-1:0] v);
    logic [63:0] w;
    w = 64'(v);
    return w[fae_pkg::OUT_W-1:0];
  endfunction

  back_state_e        state_q, state_d;
  logic [DW-1:0]      ra_q, ra_d, rb_q, rb_d, rc_q, rc_d, rd_q, rd_d;
  logic [31:0]        pc_q, pc_d;
  logic               halted_q, halted_d;
  fae_pkg::alu_op_e   mnem_q, mnem_d;
  fae_pkg::reg_sel_e  dest_q, dest_d;

  logic               out_valid_q;
  fae_pkg::status_e   res_status_q;
  logic [31:0]        res_pc_q;
  logic [31:0]        res_a_q, res_b_q, res_c_q, res_d_q;
  fae_pkg::alu_op_e   res_mnem_q;

  logic               out_free;
  logic               pop_fire;
  logic               out_load;
  fae_pkg::status_e   out_status;
  logic [63:0]        imm_ext;
  logic [DW-1:0]      imm_dw;
  logic [DW-1:0]      src;
  logic [DW-1:0]      dst;
  logic [DW-1:0]      alu;
  logic               wr_en;
  fae_pkg::reg_sel_e  wr_sel;
  logic [DW-1:0]      wr_data;

  function automatic logic [DW-1:0] rd_reg(fae_pkg::reg_sel_e s, logic [DW-1:0] a,
                                           logic [DW-1:0] b, logic [DW-1:0] c,
                                           logic [DW-1:0] d);
    logic [DW-1:0] v;
    case (s)
      fae_pkg::REG_A: v = a;
      fae_pkg::REG_B: v = b;
      fae_pkg::REG_C: v = c;
      default:        v = d;
    endcase
    return v;
  endfunction

  assign out_free    = !out_valid_q || result_o.ready;
  assign pop_ready_o = (state_q == B_IDLE) && out_free;
  assign pop_fire    = pop_valid_i && pop_ready_o;

  // Operand fetch
  always_comb begin
    imm_ext = 64'($signed(pop_entry_i.imm));
    imm_dw  = imm_ext[DW-1:0];
    src     = pop_entry_i.src_is_reg ?
              rd_reg(pop_entry_i.src_sel, ra_q, rb_q, rc_q, rd_q) : imm_dw;
    dst     = rd_reg(pop_entry_i.dest_sel, ra_q, rb_q, rc_q, rd_q);
  end

  // Combinational ALU
  always_comb begin
    case (pop_entry_i.op)
      fae_pkg::OP_ADD: alu = dst + src;
      fae_pkg::OP_SUB: alu = dst - src;
      fae_pkg::OP_INC: alu = dst + DW'(1);
      fae_pkg::OP_DEC: alu = dst - DW'(1);
      default:         alu = src;
    endcase
  end

  assign mdu_a_o = dst;
  assign mdu_b_o = src;

  // Execute control
  always_comb begin
    state_d          = state_q;
    pc_d             = pc_q;
    halted_d         = halted_q;
    mnem_d           = mnem_q;
    dest_d           = dest_q;
    out_load         = 1'b0;
    out_status       = fae_pkg::ST_OK;
    mdu_req_o.start  = 1'b0;
    mdu_req_o.is_div = 1'b0;
    wr_en            = 1'b0;
    wr_sel           = pop_entry_i.dest_sel;
    wr_data          = alu;

    case (state_q)
      B_IDLE: begin
        if (pop_fire) begin
          out_load = 1'b1;
          if (halted_q) begin
            out_status = fae_pkg::ST_HALTED;
          end else if (!pop_entry_i.arith) begin
            out_status = pop_entry_i.fixed_status;
            halted_d   = 1'b1;
          end else begin
            mnem_d = pop_entry_i.op;
            if (pop_entry_i.op == fae_pkg::OP_DIV && src == '0) begin
              out_status = fae_pkg::ST_DIVZ;
              halted_d   = 1'b1;
            end else if (!pop_entry_i.dest_ok) begin
              out_status = fae_pkg::ST_BADREG;
              halted_d   = 1'b1;
            end else if (pop_entry_i.op == fae_pkg::OP_MUL ||
                         pop_entry_i.op == fae_pkg::OP_DIV) begin
              // Long operation: result word is built when the unit finishes
              out_load         = 1'b0;
              mdu_req_o.start  = 1'b1;
              mdu_req_o.is_div = pop_entry_i.op == fae_pkg::OP_DIV;
              dest_d           = pop_entry_i.dest_sel;
              state_d          = B_CALC;
            end else begin
              wr_en = 1'b1;
              pc_d  = pc_q + 32'd1;
            end
          end
        end
      end
      B_CALC: begin
        if (mdu_rsp_i.done) begin
          wr_en    = 1'b1;
          wr_sel   = dest_q;
          wr_data  = mdu_res_i;
          pc_d     = pc_q + 32'd1;
          out_load = 1'b1;
          state_d  = B_IDLE;
        end
      end
      default: begin
        state_d = B_IDLE;
      end
    endcase

    ra_d = ra_q;
    rb_d = rb_q;
    rc_d = rc_q;
    rd_d = rd_q;
    if (wr_en) begin
      case (wr_sel)
        fae_pkg::REG_A: ra_d = wr_data;
        fae_pkg::REG_B: rb_d = wr_data;
        fae_pkg::REG_C: rc_d = wr_data;
        default:        rd_d = wr_data;
      endcase
    end
  end

  // Architectural state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= B_IDLE;
      ra_q        <= '0;
      rb_q        <= '0;
      rc_q        <= '0;
      rd_q        <= '0;
      pc_q        <= '0;
      halted_q    <= 1'b0;
      mnem_q      <= fae_pkg::OP_NONE;
      dest_q      <= fae_pkg::REG_A;
      out_valid_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      ra_q     <= ra_d;
      rb_q     <= rb_d;
      rc_q     <= rc_d;
      rd_q     <= rd_d;
      pc_q     <= pc_d;
      halted_q <= halted_d;
      mnem_q   <= mnem_d;
      dest_q   <= dest_d;
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (result_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Result word register
  always_ff @(posedge clk_i) begin
    if (out_load) begin
      res_status_q <= out_status;
      res_pc_q     <= pc_d;
      res_a_q      <= to_out(ra_d);
      res_b_q      <= to_out(rb_d);
      res_c_q      <= to_out(rc_d);
      res_d_q      <= to_out(rd_d);
      res_mnem_q   <= mnem_d;
    end
  end

  assign result_o.valid        = out_valid_q;
  assign result_o.status       = res_status_q;
  assign result_o.pc_out       = res_pc_q;
  assign result_o.a_out        = res_a_q;
  assign result_o.b_out        = res_b_q;
  assign result_o.c_out        = res_c_q;
  assign result_o.d_out        = res_d_q;
  assign result_o.mnemonic_out = res_mnem_q;

endmodule

`default_nettype wire

[hw/rtl/four_register_alu_executor_unit.sv]
`timescale 1ns / 1ps
`default_nettype none

// Four-register ALU executor.
// instr_i takes one decoded instruction word per valid/ready handshake;
// result_o gives one result word per instruction: status, program counter,
// the four registers and the last arithmetic mnemonic, all after that
// instruction.
// The front registers and classifies words into a short queue; the back
// executes them one at a time against the register file.
// MOV/ADD/SUB/INC/DEC and every non-success word reach result_o through
// the front holding register, the queue and the result word register. MUL
// and DIV run through a shared bit-serial unit, one bit per cycle, then a
// sign fix, before their result word is loaded.
// Throughput: one short word per cycle while result_o is ready; a MUL or
// DIV holds the back until the bit-serial multiply/divide loop finishes.
// Reset clears registers, program counter, mnemonic and halt flag; the
// queue comes out empty. After any non-success status every later word
// answers halted until reset.
// A stalled result_o holds its word; the back stops, the queue fills and
// then instr_i drops ready.
module four_register_alu_executor_unit #(
  parameter int unsigned DATA_WIDTH  = fae_pkg::DATA_WIDTH,
  parameter int unsigned QUEUE_DEPTH = fae_pkg::QUEUE_DEPTH
) (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  fae_instr_if.sink    instr_i,
  fae_result_if.source result_o
);

  logic                  q_push_valid;
  logic                  q_push_ready;
  fae_pkg::entry_t       q_push_entry;
  logic                  q_pop_valid;
  logic                  q_pop_ready;
  fae_pkg::entry_t       q_pop_entry;
  fae_pkg::mdu_req_t     mdu_req;
  fae_pkg::mdu_rsp_t     mdu_rsp;
  logic [DATA_WIDTH-1:0] mdu_a;
  logic [DATA_WIDTH-1:0] mdu_b;
  logic [DATA_WIDTH-1:0] mdu_res;

  fae_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .instr_i      (instr_i),
    .push_valid_o (q_push_valid),
    .push_ready_i (q_push_ready),
    .push_entry_o (q_push_entry)
  );

  fae_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (q_push_valid),
    .push_ready_o (q_push_ready),
    .push_entry_i (q_push_entry),
    .pop_valid_o  (q_pop_valid),
    .pop_ready_i  (q_pop_ready),
    .pop_entry_o  (q_pop_entry)
  );

  fae_mdu #(
    .DATA_WIDTH (DATA_WIDTH)
  ) u_mdu (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (mdu_req),
    .a_i    (mdu_a),
    .b_i    (mdu_b),
    .rsp_o  (mdu_rsp),
    .res_o  (mdu_res)
  );

  fae_back #(
    .DATA_WIDTH (DATA_WIDTH)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .pop_valid_i (q_pop_valid),
    .pop_ready_o (q_pop_ready),
    .pop_entry_i (q_pop_entry),
    .mdu_req_o   (mdu_req),
    .mdu_rsp_i   (mdu_rsp),
    .mdu_a_o     (mdu_a),
    .mdu_b_o     (mdu_b),
    .mdu_res_i   (mdu_res),
    .result_o    (result_o)
  );

  // The multiply/divide unit is only started when free
  a_mdu_start_idle : assert property (@(posedge clk_i) disable iff (!rst_ni)
    mdu_req.start |-> !mdu_rsp.busy)
    else $error("mdu started while busy");

  // Completion only follows a busy cycle
  a_mdu_done_busy : assert property (@(posedge clk_i) disable iff (!rst_ni)
    mdu_rsp.done |-> $past(mdu_rsp.busy))
    else $error("mdu done without a running operation");

  // No word leaves the queue while a long operation runs
  a_no_pop_busy : assert property (@(posedge clk_i) disable iff (!rst_ni)
    mdu_rsp.busy |-> !(q_pop_valid && q_pop_ready))
    else $error("queue pop during mdu operation");

  // Every popped word either yields a result or starts the unit
  a_pop_progress : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (q_pop_valid && q_pop_ready) |=> (result_o.valid || mdu_rsp.busy))
    else $error("popped word lost");

endmodule

`default_nettype wire

[sim/fae_result_checker.sv]
`timescale 1ns / 1ps

// Watches both channels of the executor, keeps its own copy of the
// architectural state and checks every result word against it.
module fae_result_checker
  import fae_pkg::*;
(
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  fae_instr_if             instr_mon_i,
  fae_result_if            result_mon_i,
  output int unsigned      mismatches_o,
  output int unsigned      in_flight_o,
  output int unsigned      words_checked_o,
  output logic [3:0][31:0] arch_regs_o
);

  typedef struct {
    status_e     status;
    logic [31:0] pc;
    logic [31:0] ax;
    logic [31:0] bx;
    logic [31:0] cx;
    logic [31:0] dx;
    alu_op_e     mnem;
  } retire_t;

  // architectural copy
  logic [3:0][31:0] gpr;
  logic [31:0]      pc_q;
  logic             halted_q;
  alu_op_e          last_op;

  retire_t     retire_q[$];
  int unsigned mismatch_n;
  int unsigned checked_n;

  // signed divide, truncating toward zero; MIN / -1 wraps to MIN
  function automatic logic [31:0] quotient_toward_zero(input logic [31:0] num,
                                                       input logic [31:0] den);
    logic [31:0] num_mag;
    logic [31:0] den_mag;
    logic [31:0] q;
    num_mag = num[31] ? -num : num;
    den_mag = den[31] ? -den : den;
    q = num_mag / den_mag;
    return (num[31] ^ den[31]) ? -q : q;
  endfunction

  function automatic void compare_field(input string label, input logic [31:0] want,
                                        input logic [31:0] got);
    if (got !== want) begin
      mismatch_n++;
      $display("%0t ns: word %0d %s mismatch: expected %h, actual %h",
               $time, checked_n, label, want, got);
    end
  endfunction

  // execute one accepted instruction word and queue the state it leaves behind
  task automatic retire_instruction();
    logic [3:0]  opc;
    logic [2:0]  dest;
    logic [2:0]  dest_off;
    reg_sel_e    dest_sel;
    logic [31:0] src;
    logic [31:0] dst;
    logic [31:0] res;
    status_e     st;
    retire_t     r;
    opc  = instr_mon_i.operation;
    dest = instr_mon_i.dest_reg;
    if (halted_q) begin
      st = ST_HALTED;
    end else begin
      src = instr_mon_i.source_is_register ? gpr[instr_mon_i.source_reg]
                                           : instr_mon_i.immediate;
      // malformed line wins over everything else
      if (instr_mon_i.malformed) begin
        st = ST_BADREG;
      end else if (opc == OPC_EMPTY) begin
        st = ST_EMPTY;
      end else if (opc == OPC_END) begin
        st = ST_END;
      end else if (opc > OPC_END) begin
        st = ST_BADINS;
      end else begin
        // arithmetic op is recorded even if it then fails
        last_op = alu_op_e'(opc[2:0]);
        if (opc == OPC_DIV && src == '0) begin
          st = ST_DIVZ;
        end else if (dest < DEST_AX || dest > DEST_DX) begin
          st = ST_BADREG;
        end else begin
          dest_off = dest - DEST_AX;
          dest_sel = reg_sel_e'(dest_off[1:0]);
          dst = gpr[dest_sel];
          case (opc)
            OPC_MOV: res = src;
            OPC_ADD: res = dst + src;
            OPC_SUB: res = dst - src;
            OPC_MUL: res = dst * src;
            OPC_DIV: res = quotient_toward_zero(dst, src);
            OPC_INC: res = dst + 32'd1;
            default: res = dst - 32'd1;
          endcase
          gpr[dest_sel] = res;
          st = ST_OK;
        end
      end
      if (st == ST_OK) pc_q = pc_q + 32'd1;
      else halted_q = 1'b1;
    end
    r.status = st;
    r.pc     = pc_q;
    r.ax     = gpr[REG_A];
    r.bx     = gpr[REG_B];
    r.cx     = gpr[REG_C];
    r.dx     = gpr[REG_D];
    r.mnem   = last_op;
    retire_q.push_back(r);
  endtask

  task automatic check_result();
    retire_t e;
    if (retire_q.size() == 0) begin
      mismatch_n++;
      $display("%0t ns: unexpected result word: expected none, actual status %0d pc %h",
               $time, result_mon_i.status, result_mon_i.pc_out);
    end else begin
      e = retire_q.pop_front();
      compare_field("status", e.status, result_mon_i.status);
      compare_field("pc", e.pc, result_mon_i.pc_out);
      compare_field("AX", e.ax, result_mon_i.a_out);
      compare_field("BX", e.bx, result_mon_i.b_out);
      compare_field("CX", e.cx, result_mon_i.c_out);
      compare_field("DX", e.dx, result_mon_i.d_out);
      compare_field("mnemonic", e.mnem, result_mon_i.mnemonic_out);
      checked_n++;
    end
  endtask

  // both channels sampled on the same edge the core sees
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gpr        = '0;
      pc_q       = '0;
      halted_q   = 1'b0;
      last_op    = OP_NONE;
      mismatch_n = 0;
      checked_n  = 0;
      retire_q.delete();
    end else begin
      if (result_mon_i.valid && result_mon_i.ready) check_result();
      if (instr_mon_i.valid && instr_mon_i.ready) retire_instruction();
    end
    mismatches_o    <= mismatch_n;
    in_flight_o     <= retire_q.size();
    words_checked_o <= checked_n;
    arch_regs_o     <= gpr;
  end

endmodule

[sim/tb_four_register_alu_executor_unit.sv]
`timescale 1ns / 1ps

// Stimulus and verdict for the four-register ALU executor.
module tb_four_register_alu_executor_unit;
  import fae_pkg::*;

  localparam logic [2:0] DEST_BX = DEST_AX + 3'd1;
  localparam logic [2:0] DEST_CX = DEST_AX + 3'd2;
  localparam int unsigned RANDOM_WORDS = 1300;
  localparam int unsigned HALTED_WORDS = 40;
  localparam int unsigned SETTLE_CYCLES = 40;

  // the one error that ends normal execution in this run
  typedef enum logic [2:0] {
    STOP_MALFORMED,
    STOP_EMPTY,
    STOP_END,
    STOP_UNKNOWN,
    STOP_DIVZ,
    STOP_BADDEST
  } stop_cause_e;

  logic clk_i;
  logic rst_ni;

  fae_instr_if  instr_bus ();
  fae_result_if result_bus ();

  int unsigned      mismatches;
  int unsigned      in_flight;
  int unsigned      words_checked;
  logic [3:0][31:0] arch_regs;

  int unsigned burst_left;
  int unsigned words_sent;

  four_register_alu_executor_unit dut (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .instr_i (instr_bus),
    .result_o(result_bus)
  );

  fae_result_checker u_checker (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .instr_mon_i    (instr_bus),
    .result_mon_i   (result_bus),
    .mismatches_o   (mismatches),
    .in_flight_o    (in_flight),
    .words_checked_o(words_checked),
    .arch_regs_o    (arch_regs)
  );

  // clock and reset
  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  initial begin
    rst_ni = 1'b0;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
  end

  // run limit
  initial begin
    #10_000_000;
    $display("tb: timed out, %0d results still outstanding", in_flight);
    $display("tb: failure");
    $finish;
  end

  // result side: ready runs of random length, sometimes long
  initial begin : result_stall_pattern
    int unsigned run_len;
    result_bus.ready <= 1'b0;
    forever begin
      run_len = ($urandom_range(0, 3) == 0) ? $urandom_range(40, 150) : $urandom_range(1, 15);
      repeat (run_len) begin
        @(posedge clk_i);
        result_bus.ready <= 1'b1;
      end
      run_len = $urandom_range(1, 12);
      repeat (run_len) begin
        @(posedge clk_i);
        result_bus.ready <= 1'b0;
      end
    end
  end

  // operand mix: extremes, small values and full random
  function automatic logic [31:0] pick_operand();
    case ($urandom_range(0, 9))
      0: return 32'h8000_0000;
      1: return 32'h7FFF_FFFF;
      2: return 32'hFFFF_FFFF;
      3: return 32'h0;
      4, 5, 6: return 32'($urandom_range(0, 32) - 16);
      default: return $urandom();
    endcase
  endfunction

  // drive one word, wait for it to be taken, then maybe open a gap
  task automatic send_word(input logic [3:0] opc, input logic bad_line, input logic [2:0] dest,
                           input logic from_reg, input reg_sel_e src, input logic [31:0] imm);
    instr_bus.valid              <= 1'b1;
    instr_bus.operation          <= opc;
    instr_bus.malformed          <= bad_line;
    instr_bus.dest_reg           <= dest;
    instr_bus.source_is_register <= from_reg;
    instr_bus.source_reg         <= src;
    instr_bus.immediate          <= imm;
    do @(posedge clk_i); while (!instr_bus.ready);
    words_sent++;
    if (burst_left == 0) begin
      instr_bus.valid <= 1'b0;
      repeat ($urandom_range(1, 10)) @(posedge clk_i);
      burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(30, 120) : $urandom_range(0, 12);
    end else begin
      burst_left--;
    end
  endtask

  // hold off until every outstanding word has come back
  task automatic drain_core();
    instr_bus.valid <= 1'b0;
    do @(posedge clk_i); while (in_flight != 0);
  endtask

  initial begin : stimulus
    logic [3:0]  opc;
    logic        bad_line;
    logic [2:0]  dest;
    logic        from_reg;
    reg_sel_e    src;
    logic [31:0] imm;
    int unsigned pick;
    int unsigned directed_n;
    stop_cause_e cause;

    instr_bus.valid              <= 1'b0;
    instr_bus.operation          <= OPC_EMPTY;
    instr_bus.malformed          <= 1'b0;
    instr_bus.dest_reg           <= DEST_AX;
    instr_bus.source_is_register <= 1'b0;
    instr_bus.source_reg         <= REG_A;
    instr_bus.immediate          <= '0;
    words_sent = 0;
    burst_left = $urandom_range(0, 12);
    do @(posedge clk_i); while (!rst_ni);

    // directed: extremes, wraps, every arithmetic op
    send_word(OPC_MOV, 1'b0, DEST_AX, 1'b0, REG_A, 32'h7FFF_FFFF);
    send_word(OPC_MOV, 1'b0, DEST_BX, 1'b0, REG_A, 32'h8000_0000);
    send_word(OPC_MOV, 1'b0, DEST_CX, 1'b0, REG_A, 32'hFFFF_FFFF);
    send_word(OPC_MOV, 1'b0, DEST_DX, 1'b1, REG_C, 32'h0);
    send_word(OPC_ADD, 1'b0, DEST_AX, 1'b0, REG_A, 32'd1);          // MAX + 1 -> MIN
    send_word(OPC_SUB, 1'b0, DEST_BX, 1'b0, REG_A, 32'd1);          // MIN - 1 -> MAX
    send_word(OPC_DIV, 1'b0, DEST_AX, 1'b1, REG_D, 32'h0);          // MIN / -1 wraps
    send_word(OPC_MUL, 1'b0, DEST_BX, 1'b1, REG_B, 32'h0);          // MAX * MAX, low half
    send_word(OPC_INC, 1'b0, DEST_CX, 1'b1, REG_D, 32'hFFFF_FFFF);  // operand ignored
    send_word(OPC_DEC, 1'b0, DEST_CX, 1'b0, REG_A, 32'h0);          // zero operand ignored
    send_word(OPC_MOV, 1'b0, DEST_CX, 1'b0, REG_A, 32'hFFFF_FFF9);
    send_word(OPC_DIV, 1'b0, DEST_CX, 1'b0, REG_A, 32'd2);          // -7 / 2 -> -3
    send_word(OPC_MOV, 1'b0, DEST_DX, 1'b0, REG_A, 32'd7);
    send_word(OPC_DIV, 1'b0, DEST_DX, 1'b0, REG_A, 32'hFFFF_FFFE);  // 7 / -2 -> -3
    send_word(OPC_MUL, 1'b0, DEST_DX, 1'b0, REG_A, 32'h8000_0000);
    send_word(OPC_ADD, 1'b0, DEST_DX, 1'b1, REG_A, 32'h0);
    send_word(OPC_SUB, 1'b0, DEST_AX, 1'b1, REG_B, 32'h0);
    send_word(OPC_MUL, 1'b0, DEST_CX, 1'b0, REG_A, 32'hFFFF_FFFF);
    send_word(OPC_DIV, 1'b0, DEST_AX, 1'b1, REG_C, 32'h0);
    send_word(OPC_MOV, 1'b0, DEST_DX, 1'b0, REG_A, 32'h8000_0000);
    send_word(OPC_DEC, 1'b0, DEST_DX, 1'b0, REG_A, 32'h1234_5678);  // MIN - 1 -> MAX
    send_word(OPC_INC, 1'b0, DEST_DX, 1'b1, REG_B, 32'h0);          // MAX + 1 -> MIN
    directed_n = words_sent;
    drain_core();

    // random well-formed program; the core must keep running throughout
    repeat (RANDOM_WORDS) begin
      pick     = $urandom_range(0, 99);
      opc      = (pick < 16) ? OPC_MOV : (pick < 30) ? OPC_ADD : (pick < 44) ? OPC_SUB :
                 (pick < 58) ? OPC_MUL : (pick < 74) ? OPC_DIV : (pick < 87) ? OPC_INC : OPC_DEC;
      dest     = DEST_AX + 3'($urandom_range(0, 3));
      from_reg = $urandom_range(0, 1);
      src      = reg_sel_e'($urandom_range(0, 3));
      imm      = pick_operand();
      if (opc == OPC_DIV) begin
        // divisor must be nonzero: look at the settled registers first
        if (from_reg) begin
          drain_core();
          if (arch_regs[src] == '0) from_reg = 1'b0;
        end
        while (!from_reg && imm == '0) imm = pick_operand();
      end
      send_word(opc, 1'b0, dest, from_reg, src, imm);
    end

    // one terminating error, chosen per run
    cause    = stop_cause_e'($urandom_range(0, 5));
    bad_line = 1'b0;
    dest     = 3'($urandom_range(0, 7));
    from_reg = $urandom_range(0, 1);
    src      = reg_sel_e'($urandom_range(0, 3));
    imm      = $urandom();
    case (cause)
      STOP_MALFORMED: begin
        opc      = 4'($urandom_range(0, 15));
        bad_line = 1'b1;
      end
      STOP_EMPTY: opc = OPC_EMPTY;
      STOP_END: opc = OPC_END;
      STOP_UNKNOWN: opc = 4'($urandom_range(9, 15));
      STOP_DIVZ: begin
        // zero divisor is flagged ahead of any destination problem
        opc      = OPC_DIV;
        from_reg = 1'b0;
        imm      = '0;
      end
      default: begin
        opc = 4'($urandom_range(1, 7));
        case ($urandom_range(0, 3))
          0: dest = 3'd0;
          default: dest = DEST_DX + 3'($urandom_range(1, 3));
        endcase
        if (opc == OPC_DIV) begin
          from_reg = 1'b0;
          imm      = 32'h8000_0000 | 32'($urandom_range(0, 1023));
        end
      end
    endcase
    send_word(opc, bad_line, dest, from_reg, src, imm);

    // everything after that must answer halted, whatever the word holds
    repeat (HALTED_WORDS) begin
      send_word(4'($urandom_range(0, 15)), 1'($urandom_range(0, 1)), 3'($urandom_range(0, 7)),
                1'($urandom_range(0, 1)), reg_sel_e'($urandom_range(0, 3)), $urandom());
    end

    // wind down and let any late word show up
    instr_bus.valid <= 1'b0;
    do @(posedge clk_i); while (in_flight != 0);
    repeat (SETTLE_CYCLES) @(posedge clk_i);

    $display("tb: %0d words sent (%0d directed), %0d results checked",
             words_sent, directed_n, words_checked);
    $display("tb: normal execution ended by %s, then %0d words against the halted core",
             cause.name(), HALTED_WORDS);
    if (in_flight != 0)
      $display("%0t ns: %0d expected results never arrived", $time, in_flight);
    if (mismatches == 0 && in_flight == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
